### hdl/pftl_pkg.sv
// Shared types and constants for the port filter with trace-driven loss.
// Used by every module under hdl; depends on nothing.
package pftl_pkg;

	// Loss-trace ring size; the ring index and the trace store follow from it.
	localparam int TRACE_DEPTH = 8192;
	localparam int RING_W      = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;

	// Fixed field widths of the item ports.
	localparam int ADDR_W = 13;
	localparam int BYTE_W = 8;
	localparam int PORT_W = 16;
	localparam int POS_W  = 7;

	// Configuration registers.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_A = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_B = 1'd1;
	localparam logic [PORT_W-1:0]    FILTER_PORT_RESET = 16'd2112;

	// Request codes of an input item.
	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_TRACE = 1'b1;

	// Header offsets and values.
	localparam logic [POS_W-1:0]  POS_ETYPE_HI = 7'd12;
	localparam logic [POS_W-1:0]  POS_ETYPE_LO = 7'd13;
	localparam logic [POS_W-1:0]  POS_IHL      = 7'd14;
	localparam logic [POS_W-1:0]  POS_PROTO    = 7'd23;
	localparam logic [POS_W-1:0]  POS_MIN_LAST = 7'd33;
	localparam logic [POS_W-1:0]  POS_MAX      = 7'd127;
	localparam logic [BYTE_W-1:0] ETYPE_IPV4_HI = 8'h08;
	localparam logic [BYTE_W-1:0] ETYPE_IPV4_LO = 8'h00;
	localparam logic [BYTE_W-1:0] PROTO_TCP     = 8'd6;
	localparam logic [BYTE_W-1:0] PROTO_UDP     = 8'd17;

	// Front-to-back queue.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic {
		JOB_TRACE_WR = 1'b0,
		JOB_VERDICT  = 1'b1
	} job_kind_t;

	typedef struct packed {
		job_kind_t           kind;
		logic                hit;   // verdict job: frame matched a filter port
		logic [ADDR_W-1:0]   addr;  // trace write job: entry
		logic                drop;  // trace write job: value
	} job_t;

	typedef struct packed {
		logic clearing;  // trace store sweep after reset in progress
	} back_stat_t;

endpackage

### hdl/pftl_front.sv
// Front end: takes items, parses the frame header byte by byte, turns each
// trace write and each frame end into a job. Depends on pftl_pkg.
module pftl_front import pftl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  last_byte,
	input  logic [ADDR_W-1:0]     trace_addr,
	input  logic                  trace_drop,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_full,
	input  back_stat_t            back_stat,
	output logic                  push,
	output job_t                  push_job
);

	logic [PORT_W-1:0] filter_a_q, filter_b_q;
	logic [POS_W-1:0]  pos_q;
	logic              eth_ok_q, tr_ok_q;
	logic [3:0]        hlen_q;
	logic [PORT_W-1:0] src_q, dst_q;

	logic              accept, frame_acc;
	logic              eth_nxt, tr_nxt;
	logic [3:0]        hlen_nxt;
	logic [PORT_W-1:0] src_nxt, dst_nxt;
	logic [POS_W-1:0]  offset, rel;
	logic              in_ports, cand, hit;

	assign in_stall  = q_full | back_stat.clearing;
	assign accept    = in_valid & ~in_stall;
	assign frame_acc = accept & (req_type == REQ_FRAME);

	always_comb begin
		eth_nxt  = eth_ok_q;
		hlen_nxt = hlen_q;
		tr_nxt   = tr_ok_q;
		if (pos_q == POS_ETYPE_HI) begin
			eth_nxt = (data_byte == ETYPE_IPV4_HI);
		end else if (pos_q == POS_ETYPE_LO) begin
			eth_nxt = eth_ok_q & (data_byte == ETYPE_IPV4_LO);
		end else if (pos_q == POS_IHL) begin
			hlen_nxt = data_byte[3:0];
		end else if (pos_q == POS_PROTO) begin
			tr_nxt = (data_byte == PROTO_TCP) | (data_byte == PROTO_UDP);
		end

		// ports sit at 14 + 4*IHL, using the IHL of this very byte at offset 14
		offset   = POS_IHL + {1'b0, hlen_nxt, 2'b00};
		rel      = pos_q - offset;
		in_ports = (pos_q >= offset) & (rel[POS_W-1:2] == '0);
		src_nxt  = src_q;
		dst_nxt  = dst_q;
		if (in_ports) begin
			if (!rel[1]) begin
				src_nxt = {src_q[BYTE_W-1:0], data_byte};
			end else begin
				dst_nxt = {dst_q[BYTE_W-1:0], data_byte};
			end
		end

		cand = eth_nxt & tr_nxt & (pos_q >= POS_MIN_LAST) & (pos_q >= offset + 7'd3);
		hit  = cand & ((src_nxt == filter_a_q) | (src_nxt == filter_b_q) |
		               (dst_nxt == filter_a_q) | (dst_nxt == filter_b_q));
	end

	always_comb begin
		push          = accept & ((req_type == REQ_TRACE) | last_byte);
		push_job.kind = (req_type == REQ_TRACE) ? JOB_TRACE_WR : JOB_VERDICT;
		push_job.hit  = hit;
		push_job.addr = trace_addr;
		push_job.drop = trace_drop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_a_q <= FILTER_PORT_RESET;
			filter_b_q <= FILTER_PORT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FILTER_A: filter_a_q <= cfg_data[PORT_W-1:0];
				REG_FILTER_B: filter_b_q <= cfg_data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			eth_ok_q <= 1'b0;
			hlen_q   <= '0;
			tr_ok_q  <= 1'b0;
			src_q    <= '0;
			dst_q    <= '0;
		end else if (frame_acc) begin
			if (last_byte) begin
				pos_q    <= '0;
				eth_ok_q <= 1'b0;
				hlen_q   <= '0;
				tr_ok_q  <= 1'b0;
				src_q    <= '0;
				dst_q    <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				eth_ok_q <= eth_nxt;
				hlen_q   <= hlen_nxt;
				tr_ok_q  <= tr_nxt;
				src_q    <= src_nxt;
				dst_q    <= dst_nxt;
			end
		end
	end

endmodule

### hdl/pftl_queue.sv
// Short job queue between the front end and the back end.
// Depends on pftl_pkg for the job type and depth.
module pftl_queue import pftl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	job_t                entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                do_push, do_pop;

	assign full       = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

### hdl/pftl_back.sv
// Back end: owns the loss-trace store and the ring index, runs trace writes
// and verdict lookups in queue order, holds the result register.
// Depends on pftl_pkg.
module pftl_back import pftl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  job_t              head_job,
	output logic              pop,
	output back_stat_t        stat,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              verdict,
	output logic              port_matched,
	output logic [ADDR_W-1:0] trace_slot
);

	logic                trace_mem [TRACE_DEPTH];
	logic                clr_q;
	logic [RING_W-1:0]   clr_cnt_q;
	logic [RING_W-1:0]   ring_q;

	logic                s1_valid_q, s1_hit_s1, rdata_s1;
	logic [ADDR_W-1:0]   s1_slot_s1;
	logic                out_valid_q, verdict_q, matched_q;
	logic [ADDR_W-1:0]   slot_q;

	logic                out_free, pop_ok, is_verdict, rd_en;
	logic                wr_en, wr_data;
	logic [RING_W-1:0]   wr_addr;
	logic [31:0]         addr32, ring32;

	assign stat.clearing = clr_q;
	assign out_free      = ~out_valid_q | ~out_stall;
	assign pop_ok        = ~clr_q & (~s1_valid_q | out_free);
	assign pop           = head_valid & pop_ok;
	assign is_verdict    = (head_job.kind == JOB_VERDICT);
	assign rd_en         = pop & is_verdict & head_job.hit;
	assign addr32        = 32'(head_job.addr);
	assign ring32        = 32'(ring_q);

	always_comb begin
		if (clr_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = 1'b0;
		end else begin
			// entries beyond the ring are ignored
			wr_en   = pop & ~is_verdict & (addr32 < 32'(TRACE_DEPTH));
			wr_addr = addr32[RING_W-1:0];
			wr_data = head_job.drop;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			trace_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= trace_mem[ring_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == RING_W'(TRACE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
		end else if (rd_en) begin
			ring_q <= (ring_q == RING_W'(TRACE_DEPTH - 1)) ? '0 : ring_q + 1'b1;
		end
	end

	// lookup stage: memory read data lands here with the job's tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pop & is_verdict) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop & is_verdict) begin
			s1_hit_s1  <= head_job.hit;
			s1_slot_s1 <= head_job.hit ? ring32[ADDR_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free & s1_valid_q) begin
			verdict_q <= s1_hit_s1 & rdata_s1;
			matched_q <= s1_hit_s1;
			slot_q    <= s1_slot_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign port_matched = matched_q;
	assign trace_slot   = slot_q;

endmodule

### hdl/port_filter_trace_loss_dropper.sv
// TCP/UDP port filter with trace-driven loss: top level.
// Instantiates pftl_front, pftl_queue and pftl_back; depends on pftl_pkg.
//
// Takes one item per clock while in_stall is low: frame bytes in wire order,
// or writes of single loss-trace entries, both in the same stream and carried
// out in order. One verdict comes out for each frame byte marked last, via the
// job queue, the lookup stage and the result register; the four-entry job
// queue and the result register let either side stall without holding up the
// other. After reset the block sweeps the trace store clear, one entry per
// cycle (all TRACE_DEPTH entries, 8192 as built); in_stall stays high until
// it is done, while configuration writes are taken as usual. The user must
// write filter ports only while the block is idle; the block does not check.
module port_filter_trace_loss_dropper import pftl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  last_byte,
	input  logic [ADDR_W-1:0]     trace_addr,
	input  logic                  trace_drop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  verdict,
	output logic                  port_matched,
	output logic [ADDR_W-1:0]     trace_slot
);

	logic       push, q_full, pop, head_valid;
	job_t       push_job, head_job;
	back_stat_t back_stat;

	pftl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.trace_addr (trace_addr),
		.trace_drop (trace_drop),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.back_stat  (back_stat),
		.push       (push),
		.push_job   (push_job)
	);

	pftl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	pftl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.stat         (back_stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.port_matched (port_matched),
		.trace_slot   (trace_slot)
	);

endmodule
